### hdl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// beat types, queue entry, status and request codes, back end states
// ----------------------------------------------------------------------------
package ght_pkg;

   localparam int MAX_GEN_BITS   = 12;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RING_PRESENT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DAEMON_EPOCH = 1'b1;

   localparam logic [2:0] REQ_REGISTER   = 3'd0;
   localparam logic [2:0] REQ_UNREGISTER = 3'd1;
   localparam logic [2:0] REQ_QUERY      = 3'd2;
   localparam logic [2:0] REQ_RESOLVE    = 3'd3;
   localparam logic [2:0] REQ_CLEAR      = 3'd4;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BAD       = 4'd1;
   localparam logic [3:0] ST_FULL      = 4'd2;
   localparam logic [3:0] ST_NO_RING   = 4'd3;
   localparam logic [3:0] ST_KIND      = 4'd4;
   localparam logic [3:0] ST_EPOCH     = 4'd5;
   localparam logic [3:0] ST_NOT_LIVE  = 4'd6;
   localparam logic [3:0] ST_GEN       = 4'd7;
   localparam logic [3:0] ST_NOT_FOUND = 4'd8;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  obj_kind;
      logic [31:0] obj_handle;
      logic [7:0]  slot_query;
      logic [31:0] token_in;
   } request_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  slot_out;
      logic [31:0] token_out;
      logic [31:0] handle_out;
   } response_type;

   typedef enum logic [2:0] {
      OP_REGISTER,
      OP_UNREGISTER,
      OP_QUERY,
      OP_RESOLVE,
      OP_CLEAR,
      OP_REPLY
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [3:0]              status;
      logic [3:0]              kind;
      logic [31:0]             word;
      logic [7:0]              slot;
      logic [MAX_GEN_BITS-1:0] gen;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_LOOKUP,
      BK_FINISH,
      BK_SCAN
   } back_state_type;

endpackage

### hdl/ght_front.sv
// ----------------------------------------------------------------------------
// ght_front: request intake and classification
// holds the csr registers, settles bad requests and the token checks that
// need no slot state, and hands a decoded entry to the queue
// ----------------------------------------------------------------------------
module ght_front #(
   parameter int KIND_BITS  = 4,
   parameter int INDEX_BITS = 4,
   parameter int GEN_BITS   = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [ght_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [ght_pkg::CSR_DATA_BITS-1:0]        csr_wdata,
   input  logic                                     start,
   output logic                                     busy,
   input  ght_pkg::request_type                     req_data,
   input  ght_pkg::queue_status_type                q_stat,
   output logic                                     push,
   output ght_pkg::entry_type                       push_data
);

   localparam int EPOCH_SHIFT = KIND_BITS + INDEX_BITS + GEN_BITS;
   localparam int EPOCH_BITS  = 32 - EPOCH_SHIFT;
   localparam int GW          = ght_pkg::MAX_GEN_BITS;

   logic                                   ring_ff, ring_in;
   logic [ght_pkg::CSR_DATA_BITS-1:0]      epoch_ff, epoch_in;

   logic [31:0]            epoch_wide;
   logic [EPOCH_BITS-1:0]  epoch_field;
   logic [KIND_BITS-1:0]   tok_kind;
   logic [INDEX_BITS-1:0]  tok_idx;
   logic [GEN_BITS-1:0]    tok_gen;
   logic [EPOCH_BITS-1:0]  tok_epoch;

   always_comb begin
      ring_in  = ring_ff;
      epoch_in = epoch_ff;
      if (csr_we) begin
         case (csr_index)
            ght_pkg::CSR_RING_PRESENT: ring_in  = csr_wdata[0];
            ght_pkg::CSR_DAEMON_EPOCH: epoch_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff  <= 1'b0;
         epoch_ff <= '0;
      end else begin
         ring_ff  <= ring_in;
         epoch_ff <= epoch_in;
      end
   end

   assign busy = q_stat.full;
   assign push = start && !q_stat.full;

   // epoch as it stands in a token: zero without ring, cut to the field
   assign epoch_wide  = ring_ff ? 32'(epoch_ff) : 32'd0;
   assign epoch_field = epoch_wide[EPOCH_BITS-1:0];

   assign tok_kind  = req_data.token_in[KIND_BITS-1:0];
   assign tok_idx   = req_data.token_in[KIND_BITS +: INDEX_BITS];
   assign tok_gen   = req_data.token_in[KIND_BITS+INDEX_BITS +: GEN_BITS];
   assign tok_epoch = req_data.token_in[31:EPOCH_SHIFT];

   always_comb begin
      push_data        = '0;
      push_data.op     = ght_pkg::OP_REPLY;
      push_data.status = ght_pkg::ST_BAD;
      push_data.kind   = req_data.obj_kind;
      push_data.word   = req_data.obj_handle;
      push_data.slot   = req_data.slot_query;
      case (req_data.req_type)
         ght_pkg::REQ_REGISTER: begin
            if (req_data.obj_handle != 32'd0 && req_data.obj_kind != 4'd0) begin
               push_data.op = ght_pkg::OP_REGISTER;
            end
         end
         ght_pkg::REQ_UNREGISTER: begin
            push_data.op = ght_pkg::OP_UNREGISTER;
         end
         ght_pkg::REQ_QUERY: begin
            // epoch and index part of the token, kind and gen come from the slot
            push_data.op   = ght_pkg::OP_QUERY;
            push_data.word = (32'(epoch_field) << EPOCH_SHIFT)
                           | (32'(req_data.slot_query[INDEX_BITS-1:0]) << KIND_BITS);
         end
         ght_pkg::REQ_RESOLVE: begin
            if (!ring_ff) begin
               push_data.status = ght_pkg::ST_NO_RING;
            end else if (8'(tok_kind) != 8'(req_data.obj_kind)) begin
               push_data.status = ght_pkg::ST_KIND;
            end else if (tok_epoch != epoch_field) begin
               push_data.status = ght_pkg::ST_EPOCH;
            end else begin
               push_data.op   = ght_pkg::OP_RESOLVE;
               push_data.slot = 8'(tok_idx);
               push_data.gen  = GW'(tok_gen);
            end
         end
         ght_pkg::REQ_CLEAR: begin
            push_data.op = ght_pkg::OP_CLEAR;
         end
         default: ;
      endcase
   end

endmodule

### hdl/ght_queue.sv
// ----------------------------------------------------------------------------
// ght_queue: short entry queue between the front and back ends
// lets either side stall on its own
// ----------------------------------------------------------------------------
module ght_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ght_pkg::entry_type            push_data,
   input  logic                          pop,
   output ght_pkg::entry_type            pop_data,
   output ght_pkg::queue_status_type     q_stat
);

   localparam int DEPTH = ght_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   ght_pkg::entry_type  slot_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                do_push, do_pop;

   assign q_stat.full  = (count_ff == CW'(DEPTH));
   assign q_stat.empty = (count_ff == CW'(0));
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/ght_back.sv
// ----------------------------------------------------------------------------
// ght_back: slot table and execution sequencer
// live bits and generations in flops, kind and handle in a slot memory;
// unregister scans the memory one slot a cycle
// ----------------------------------------------------------------------------
module ght_back #(
   parameter int SLOT_COUNT = 16,
   parameter int KIND_BITS  = 4,
   parameter int INDEX_BITS = 4,
   parameter int GEN_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ght_pkg::queue_status_type     q_stat,
   output logic                          pop,
   input  ght_pkg::entry_type            pop_data,
   output logic                          rsp_strobe,
   output ght_pkg::response_type         rsp_data
);

   localparam int IDXW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int GW        = ght_pkg::MAX_GEN_BITS;
   localparam int GEN_SHIFT = KIND_BITS + INDEX_BITS;
   localparam logic [31:0]     KIND_MASK = 32'((64'd1 << KIND_BITS) - 64'd1);
   localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(SLOT_COUNT - 1);

   ght_pkg::back_state_type  state_ff, state_in;
   ght_pkg::entry_type       cur_ff, cur_in;
   logic [SLOT_COUNT-1:0]    live_ff, live_in;
   logic [GEN_BITS-1:0]      gen_ff [SLOT_COUNT];
   logic [GEN_BITS-1:0]      gen_in [SLOT_COUNT];
   logic [IDXW-1:0]          scan_ff, scan_in;
   logic                     issue_ff, issue_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [IDXW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   ght_pkg::response_type    rsp_ff, rsp_in;

   logic [3:0]               kind_mem [SLOT_COUNT];
   logic [31:0]              obj_mem  [SLOT_COUNT];
   logic [3:0]               rd_kind_ff;
   logic [31:0]              rd_obj_ff;
   logic [IDXW-1:0]          rd_addr;
   logic                     mem_we;

   logic [IDXW-1:0]          cur_idx;
   logic                     cur_live;
   logic                     free_any;
   logic [IDXW-1:0]          free_idx;
   logic                     match;

   assign pop        = (state_ff == ght_pkg::BK_IDLE) && !q_stat.empty;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign cur_idx  = cur_ff.slot[IDXW-1:0];
   assign cur_live = (cur_ff.slot < 8'(SLOT_COUNT)) && live_ff[cur_idx];
   assign rd_addr  = (state_ff == ght_pkg::BK_SCAN) ? scan_ff : cur_idx;
   assign match    = cmp_vld_ff && live_ff[cmp_idx_ff]
                     && (rd_kind_ff == cur_ff.kind) && (rd_obj_ff == cur_ff.word);

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDXW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ght_pkg::BK_IDLE: begin
            if (pop) begin
               case (pop_data.op)
                  ght_pkg::OP_UNREGISTER: state_in = ght_pkg::BK_SCAN;
                  ght_pkg::OP_QUERY:      state_in = ght_pkg::BK_LOOKUP;
                  ght_pkg::OP_RESOLVE:    state_in = ght_pkg::BK_LOOKUP;
                  default:                state_in = ght_pkg::BK_EXEC;
               endcase
            end
         end
         ght_pkg::BK_EXEC:   state_in = ght_pkg::BK_IDLE;
         ght_pkg::BK_LOOKUP: state_in = ght_pkg::BK_FINISH;
         ght_pkg::BK_FINISH: state_in = ght_pkg::BK_IDLE;
         ght_pkg::BK_SCAN: begin
            if (match || (cmp_vld_ff && cmp_idx_ff == LAST_IDX)) begin
               state_in = ght_pkg::BK_IDLE;
            end
         end
         default: state_in = ght_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      cur_in        = cur_ff;
      live_in       = live_ff;
      gen_in        = gen_ff;
      scan_in       = scan_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = scan_ff;
      mem_we        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ght_pkg::BK_IDLE: begin
            if (pop) begin
               cur_in   = pop_data;
               scan_in  = '0;
               issue_in = 1'b1;
            end
         end
         ght_pkg::BK_EXEC: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
            case (cur_ff.op)
               ght_pkg::OP_REGISTER: begin
                  if (free_any) begin
                     live_in[free_idx] = 1'b1;
                     gen_in[free_idx]  = gen_ff[free_idx] + GEN_BITS'(1);
                     mem_we            = 1'b1;
                     rsp_in.status     = ght_pkg::ST_OK;
                     rsp_in.slot_out   = 8'(free_idx);
                  end else begin
                     rsp_in.status = ght_pkg::ST_FULL;
                  end
               end
               ght_pkg::OP_CLEAR: begin
                  live_in       = '0;
                  rsp_in.status = ght_pkg::ST_OK;
               end
               default: rsp_in.status = cur_ff.status;
            endcase
         end
         ght_pkg::BK_LOOKUP: ;
         ght_pkg::BK_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
            if (cur_ff.op == ght_pkg::OP_QUERY) begin
               if (cur_live) begin
                  rsp_in.status    = ght_pkg::ST_OK;
                  rsp_in.token_out = cur_ff.word
                                   | (32'(rd_kind_ff) & KIND_MASK)
                                   | (32'(gen_ff[cur_idx]) << GEN_SHIFT);
               end else begin
                  rsp_in.status = ght_pkg::ST_NOT_FOUND;
               end
            end else begin
               if (!cur_live) begin
                  rsp_in.status = ght_pkg::ST_NOT_LIVE;
               end else if (GW'(gen_ff[cur_idx]) != cur_ff.gen) begin
                  rsp_in.status = ght_pkg::ST_GEN;
               end else begin
                  rsp_in.status     = ght_pkg::ST_OK;
                  rsp_in.handle_out = rd_obj_ff;
               end
            end
         end
         ght_pkg::BK_SCAN: begin
            // one slot read issued per cycle, compared the cycle after
            cmp_vld_in = issue_ff;
            cmp_idx_in = scan_ff;
            if (issue_ff) begin
               if (scan_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  scan_in = scan_ff + IDXW'(1);
               end
            end
            if (match) begin
               live_in[cmp_idx_ff] = 1'b0;
               rsp_strobe_in       = 1'b1;
               rsp_in              = '0;
               rsp_in.status       = ght_pkg::ST_OK;
            end else if (cmp_vld_ff && cmp_idx_ff == LAST_IDX) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               rsp_in.status = ght_pkg::ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ght_pkg::BK_IDLE;
         live_ff       <= '0;
         gen_ff        <= '{default: '0};
         issue_ff      <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         gen_ff        <= gen_in;
         issue_ff      <= issue_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   // slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         kind_mem[free_idx] <= cur_ff.kind;
         obj_mem[free_idx]  <= cur_ff.word;
      end
      rd_kind_ff <= kind_mem[rd_addr];
      rd_obj_ff  <= obj_mem[rd_addr];
   end

endmodule

### hdl/generational_handle_table_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_table_unit: object slot table with epoch tokens
//
// request beat: taken at a clock edge with start high and busy low; one
// response beat per request on rsp_data, marked by rsp_strobe for exactly
// one cycle, with no back-pressure from the receiver.
// csr port: csr_we, csr_index (0 ring present, 1 daemon epoch), csr_wdata;
// a write lands at the edge where csr_we is high.
// register, clear-all and rejected requests answer from the exec state,
// token query and resolve from a lookup state and then a finish state,
// and unregister from a scan that stops at a match or at the last slot.
// the back end sequencer takes one request at a time; the unregister scan
// reads one slot a cycle from the slot memory, and a two-entry queue lets
// the front end take requests meanwhile.
// reset: synchronous; all slots free, generations zero, csr registers zero,
// queue empty, no response pending.
// ----------------------------------------------------------------------------
module generational_handle_table_unit #(
   parameter int SLOT_COUNT = 16,
   parameter int KIND_BITS  = 4,
   parameter int INDEX_BITS = 4,
   parameter int GEN_BITS   = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  ght_pkg::request_type                 req_data,
   output logic                                 rsp_strobe,
   output ght_pkg::response_type                rsp_data,
   input  logic                                 csr_we,
   input  logic [ght_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ght_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   ght_pkg::queue_status_type  q_stat;
   ght_pkg::entry_type         push_data;
   ght_pkg::entry_type         pop_data;
   logic                       push;
   logic                       pop;

   ght_front #(
      .KIND_BITS  (KIND_BITS),
      .INDEX_BITS (INDEX_BITS),
      .GEN_BITS   (GEN_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   ght_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   ght_back #(
      .SLOT_COUNT (SLOT_COUNT),
      .KIND_BITS  (KIND_BITS),
      .INDEX_BITS (INDEX_BITS),
      .GEN_BITS   (GEN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop        (pop),
      .pop_data   (pop_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("response or busy right after reset");

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response beats in back-to-back cycles");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ght_pkg::ST_OK |->
         rsp_data.slot_out == 8'd0 && rsp_data.token_out == 32'd0
         && rsp_data.handle_out == 32'd0)
      else $error("failed response carries a payload");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.slot_out < 8'(SLOT_COUNT))
      else $error("response slot beyond table");
`endif

endmodule
